FILE: rtl/core/rlpsd_pkg.sv
// Shared types and codes for the RLP stream decoder.
// Holds event kinds, the result record and the controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package rlpsd_pkg;

    localparam logic [2:0] KIND_INLINE  = 3'd0;
    localparam logic [2:0] KIND_SSTART  = 3'd1;
    localparam logic [2:0] KIND_SBYTE   = 3'd2;
    localparam logic [2:0] KIND_LSTART  = 3'd3;
    localparam logic [2:0] KIND_LEND    = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [15:0] item_length;
        logic [3:0]  nest_depth;
    } rlpsd_evt_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic empty_end;
        logic pop;
        logic tail;
        logic flush;
    } rlpsd_cmd_t;

    typedef struct packed {
        logic discard;
        logic dec_ok;
        logic dec_empty;
        logic pop_due;
        logic tail_err;
        logic evt_valid;
        logic slot_ok;
        logic out_free;
    } rlpsd_stat_t;

endpackage

FILE: rtl/core/rlpsd_datapath.sv
// Datapath of the RLP stream decoder: parse state, list end stack,
// one held event and the result register. Depends on rlpsd_pkg.
`timescale 1ns / 1ps

module rlpsd_datapath
    import rlpsd_pkg::*;
#(
    parameter int MAX_DEPTH = 8,
    parameter int LEN_BITS  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        s_in_byte,
    input  logic              s_in_last,
    input  logic              m_ready,
    input  rlpsd_cmd_t        cmd,
    output rlpsd_stat_t       st,
    output logic              m_valid,
    output logic [2:0]        m_kind,
    output logic [7:0]        m_value,
    output logic [15:0]       m_item_length,
    output logic [3:0]        m_nest_depth,
    output logic              m_run_last
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int EW = LEN_BITS + 2;

    localparam logic [1:0] PH_PREFIX  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    logic [7:0]          byte_reg;
    logic                last_reg;
    logic [1:0]          phase_reg;
    logic                pend_list_reg;
    logic [3:0]          left_reg;
    logic [LEN_BITS-1:0] accum_reg;
    logic [LEN_BITS-1:0] payload_reg;
    logic [LEN_BITS-1:0] pos_reg;
    logic [LW-1:0]       level_reg;
    logic [LEN_BITS-1:0] end_stack_reg [MAX_DEPTH];

    rlpsd_evt_t          evt_reg;
    logic                evt_valid_reg;
    rlpsd_evt_t          out_reg;
    logic                out_last_reg;
    logic                out_valid_reg;

    logic [LEN_BITS-1:0] base_pos;
    logic [EW-1:0]       nxt;
    logic                has_parent;
    logic [LW-1:0]       lvl_m1;
    logic [LW:0]         lvl_p1;
    logic [IW-1:0]       top_idx;
    logic [LEN_BITS-1:0] top;
    logic                is_inline;
    logic                is_sstr;
    logic                is_lstr;
    logic                is_llist;
    logic [3:0]          k4;
    logic [EW-1:0]       hdr_end;
    logic                hdr_fit;
    logic                acc_over;
    logic [LEN_BITS-1:0] acc_new;
    logic [3:0]          left_dec;
    logic [LEN_BITS-1:0] payload_dec;
    logic [LEN_BITS-1:0] start_len;
    logic [EW-1:0]       item_end;
    logic                over_parent;
    logic                list_bad;
    logic                do_start;
    logic                start_list;

    logic                d_ok;
    logic                d_emit;
    logic                d_empty;
    logic                d_push;
    rlpsd_evt_t          d_evt;
    logic [1:0]          phase_next;
    logic                pend_list_next;
    logic [3:0]          left_next;
    logic [LEN_BITS-1:0] accum_next;
    logic [LEN_BITS-1:0] payload_next;

    logic                soft_rst;
    logic                new_evt;
    rlpsd_evt_t          new_evt_data;
    logic                discard;

    assign discard    = phase_reg == PH_DISCARD;
    assign has_parent = level_reg != '0;
    assign lvl_m1     = level_reg - LW'(1);
    assign lvl_p1     = {1'b0, level_reg} + (LW + 1)'(1);
    assign top_idx    = has_parent ? lvl_m1[IW-1:0] : '0;
    assign top        = end_stack_reg[top_idx];

    always_comb begin
        base_pos = (phase_reg == PH_PREFIX && !has_parent) ? '0 : pos_reg;
        nxt      = EW'(base_pos) + EW'(1);

        is_inline = byte_reg < 8'h80;
        is_sstr   = byte_reg >= 8'h80 && byte_reg <= 8'hb7;
        is_lstr   = byte_reg >= 8'hb8 && byte_reg <= 8'hbf;
        is_llist  = byte_reg >= 8'hf8;
        k4        = is_lstr ? 4'(byte_reg - 8'hb7) : 4'(byte_reg - 8'hf7);
        hdr_end   = nxt + EW'(k4);
        hdr_fit   = !has_parent || hdr_end <= EW'(top);

        acc_over    = (accum_reg >> (LEN_BITS - 8)) != '0;
        acc_new     = (accum_reg << 8) | LEN_BITS'(byte_reg);
        left_dec    = left_reg - ((left_reg != 4'd0) ? 4'd1 : 4'd0);
        payload_dec = payload_reg - ((payload_reg != '0) ? LEN_BITS'(1) : '0);

        if (phase_reg == PH_PREFIX) begin
            start_len = is_sstr ? LEN_BITS'(byte_reg - 8'h80) : LEN_BITS'(byte_reg - 8'hc0);
        end else begin
            start_len = acc_new;
        end
        item_end    = nxt + EW'(start_len);
        over_parent = has_parent && item_end > EW'(top);
        list_bad    = (item_end >> LEN_BITS) != '0 || level_reg >= LW'(MAX_DEPTH)
                      || over_parent;

        d_ok           = 1'b1;
        d_emit         = 1'b0;
        d_empty        = 1'b0;
        d_push         = 1'b0;
        d_evt.kind        = KIND_SBYTE;
        d_evt.value       = 8'd0;
        d_evt.item_length = 16'd0;
        d_evt.nest_depth  = 4'(level_reg);
        phase_next     = phase_reg;
        pend_list_next = pend_list_reg;
        left_next      = left_reg;
        accum_next     = accum_reg;
        payload_next   = payload_reg;
        do_start       = 1'b0;
        start_list     = 1'b0;

        case (phase_reg)
            PH_PREFIX: begin
                if (is_inline) begin
                    d_emit      = 1'b1;
                    d_evt.kind  = KIND_INLINE;
                    d_evt.value = byte_reg;
                end else if (is_sstr) begin
                    do_start = 1'b1;
                end else if (is_lstr || is_llist) begin
                    d_ok           = hdr_fit;
                    pend_list_next = is_llist;
                    left_next      = k4;
                    accum_next     = '0;
                    phase_next     = PH_LENGTH;
                end else begin
                    do_start   = 1'b1;
                    start_list = 1'b1;
                end
            end
            PH_LENGTH: begin
                if (acc_over) begin
                    d_ok = 1'b0;
                end else begin
                    accum_next = acc_new;
                    left_next  = left_dec;
                    if (left_dec == 4'd0) begin
                        do_start   = 1'b1;
                        start_list = pend_list_reg;
                    end
                end
            end
            default: begin
                d_emit       = 1'b1;
                d_evt.kind   = KIND_SBYTE;
                d_evt.value  = byte_reg;
                payload_next = payload_dec;
                if (payload_dec == '0) begin
                    phase_next = PH_PREFIX;
                end
            end
        endcase

        if (do_start) begin
            d_evt.item_length = 16'(start_len);
            if (!start_list) begin
                if (over_parent) begin
                    d_ok = 1'b0;
                end else begin
                    d_emit       = 1'b1;
                    d_evt.kind   = KIND_SSTART;
                    payload_next = start_len;
                    phase_next   = (start_len != '0) ? PH_PAYLOAD : PH_PREFIX;
                end
            end else begin
                if (list_bad) begin
                    d_ok = 1'b0;
                end else begin
                    d_emit           = 1'b1;
                    d_evt.kind       = KIND_LSTART;
                    d_evt.nest_depth = 4'(lvl_p1);
                    d_empty          = start_len == '0;
                    d_push           = start_len != '0;
                    phase_next       = PH_PREFIX;
                end
            end
        end
    end

    // event source for the hold stage
    always_comb begin
        new_evt                  = 1'b0;
        new_evt_data.kind        = KIND_ERROR;
        new_evt_data.value       = 8'd0;
        new_evt_data.item_length = 16'd0;
        new_evt_data.nest_depth  = 4'(level_reg);
        if (cmd.decode && !discard) begin
            new_evt = !d_ok || d_emit;
            if (d_ok) begin
                new_evt_data = d_evt;
            end
        end else if (cmd.empty_end) begin
            new_evt                 = 1'b1;
            new_evt_data.kind       = KIND_LEND;
            new_evt_data.nest_depth = 4'(lvl_p1);
        end else if (cmd.pop) begin
            new_evt           = 1'b1;
            new_evt_data.kind = KIND_LEND;
        end else if (cmd.tail) begin
            new_evt = st.tail_err;
        end
    end

    assign soft_rst = (cmd.decode && last_reg && (discard || !d_ok))
                      || (cmd.tail && last_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= s_in_byte;
            last_reg <= s_in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || soft_rst) begin
            phase_reg     <= PH_PREFIX;
            pend_list_reg <= 1'b0;
            left_reg      <= 4'd0;
            accum_reg     <= '0;
            payload_reg   <= '0;
            pos_reg       <= '0;
            level_reg     <= '0;
        end else if (cmd.decode && !discard) begin
            if (!d_ok) begin
                phase_reg <= PH_DISCARD;
            end else begin
                phase_reg     <= phase_next;
                pend_list_reg <= pend_list_next;
                left_reg      <= left_next;
                accum_reg     <= accum_next;
                payload_reg   <= payload_next;
                pos_reg       <= nxt[LEN_BITS-1:0];
                if (d_push) begin
                    level_reg <= level_reg + LW'(1);
                end
            end
        end else if (cmd.pop) begin
            level_reg <= lvl_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode && !discard && d_ok && d_push) begin
            end_stack_reg[level_reg[IW-1:0]] <= item_end[LEN_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (new_evt) begin
                evt_valid_reg <= 1'b1;
                if (evt_valid_reg) begin
                    out_valid_reg <= 1'b1;
                end else if (m_ready) begin
                    out_valid_reg <= 1'b0;
                end
            end else if (cmd.flush) begin
                evt_valid_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (new_evt) begin
            evt_reg <= new_evt_data;
            if (evt_valid_reg) begin
                out_reg      <= evt_reg;
                out_last_reg <= 1'b0;
            end
        end else if (cmd.flush) begin
            out_reg      <= evt_reg;
            out_last_reg <= 1'b1;
        end
    end

    always_comb begin
        st.discard   = discard;
        st.dec_ok    = d_ok;
        st.dec_empty = d_empty;
        st.pop_due   = has_parent && top <= pos_reg;
        st.tail_err  = last_reg && (phase_reg != PH_PREFIX || has_parent);
        st.evt_valid = evt_valid_reg;
        st.out_free  = !out_valid_reg || m_ready;
        st.slot_ok   = !evt_valid_reg || !out_valid_reg || m_ready;
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_value       = out_reg.value;
    assign m_item_length = out_reg.item_length;
    assign m_nest_depth  = out_reg.nest_depth;
    assign m_run_last    = out_last_reg;

endmodule

FILE: rtl/core/rlpsd_ctrl.sv
// Controller of the RLP stream decoder: sequences decode, list closes,
// trailing error and the final transfer of each byte. Depends on rlpsd_pkg.
`timescale 1ns / 1ps

module rlpsd_ctrl
    import rlpsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rlpsd_stat_t st,
    output rlpsd_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EMPTY  = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                if (st.discard) begin
                    state_next = S_IDLE;
                end else if (!st.dec_ok) begin
                    state_next = S_FLUSH;
                end else if (st.dec_empty) begin
                    state_next = S_EMPTY;
                end else begin
                    state_next = S_POP;
                end
            end
            S_EMPTY: begin
                if (st.slot_ok) begin
                    cmd.empty_end = 1'b1;
                    state_next    = S_POP;
                end
            end
            S_POP: begin
                if (st.pop_due) begin
                    cmd.pop = st.slot_ok;
                end else if (!st.tail_err || st.slot_ok) begin
                    cmd.tail   = 1'b1;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!st.evt_valid) begin
                    state_next = S_IDLE;
                end else if (st.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/rlp_stream_decoder_top.sv
// RLP stream decoder: takes one byte of an RLP frame per input transfer and
// emits the token events it causes. Input channel s_valid/s_ready carries
// s_in_byte and s_in_last (final byte of the top-level frame). Result channel
// m_valid/m_ready carries m_kind, m_value, m_item_length, m_nest_depth and
// m_run_last, which marks the last event caused by one input byte; a byte
// may cause no event, or several (list closes, empty list, trailing error).
// One byte is in work at a time. A byte passes from transfer to readiness
// for the next through accept, decode, close check and final transfer; an
// empty list adds an empty-list end step after decode, and each list close
// adds a close step. A byte that raises an error goes from decode to the
// final transfer, and bytes dropped after an error go from decode back to
// accept. Each event is held first and then moves to the result register.
// A held event and the result register hold events while the receiver
// stalls; the sequencer waits only when both are full.
// Reset (aresetn low at a rising edge) clears the parse state, the open list
// count and both result stages; the list end stack needs no clearing.
// Parameters: MAX_DEPTH sets the stack of open lists, LEN_BITS the length
// and position range.
`timescale 1ns / 1ps

module rlp_stream_decoder_top
    import rlpsd_pkg::*;
#(
    parameter int MAX_DEPTH = 8,
    parameter int LEN_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_value,
    output logic [15:0] m_item_length,
    output logic [3:0]  m_nest_depth,
    output logic        m_run_last
);

    rlpsd_cmd_t  cmd;
    rlpsd_stat_t st;

    rlpsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rlpsd_datapath #(
        .MAX_DEPTH (MAX_DEPTH),
        .LEN_BITS  (LEN_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_in_byte     (s_in_byte),
        .s_in_last     (s_in_last),
        .m_ready       (m_ready),
        .cmd           (cmd),
        .st            (st),
        .m_valid       (m_valid),
        .m_kind        (m_kind),
        .m_value       (m_value),
        .m_item_length (m_item_length),
        .m_nest_depth  (m_nest_depth),
        .m_run_last    (m_run_last)
    );

endmodule
